FILE: hw/rtl/ulc_pkg.sv
// Shared types and constants of the ULPI link controller.
package ulc_pkg;

    localparam logic [1:0] CMD_WRITE_CODE = 2'b10;
    localparam logic [1:0] CMD_READ_CODE  = 2'b11;
    localparam logic [3:0] TXCMD_NIBBLE   = 4'b0100;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // Register access phases, one-hot.
    typedef enum logic [6:0] {
        PH_IDLE         = 7'b0000001,
        PH_WAIT_DIR_OUT = 7'b0000010,
        PH_SET_ADDR     = 7'b0000100,
        PH_SET_DATA     = 7'b0001000,
        PH_STOP         = 7'b0010000,
        PH_WAIT_DIR_IN  = 7'b0100000,
        PH_GET_DATA     = 7'b1000000
    } phase_t;

    // One cycle of pins and requests, last field in the lowest bits.
    typedef struct packed {
        logic [4:0] pad;
        logic [7:0] tx_data;
        logic       tx_valid;
        logic [7:0] req_wdata;
        logic [5:0] req_addr;
        logic       req_read;
        logic       req_valid;
        logic [7:0] phy_data;
        logic       phy_nxt;
        logic       phy_dir;
    } in_item_t;

    // One cycle of results, last field in the lowest bits.
    typedef struct packed {
        logic       pad;
        logic [7:0] rx_status;
        logic       tx_ready;
        logic [7:0] rx_byte;
        logic       rx_eop;
        logic       rx_sop;
        logic       rx_valid;
        logic [7:0] req_rdata;
        logic       req_done;
        logic       stop_pin;
        logic       bus_drive;
        logic [7:0] bus_out;
    } out_item_t;

    // What the access sequencer hands to the framing logic and the registers.
    typedef struct packed {
        logic [7:0] bus;
        logic       stp;
        logic       done;
        logic [7:0] rdata;
        phase_t     phase;
        logic [7:0] cmd;
        logic       wdata_we;
    } seq_out_t;

endpackage

FILE: hw/rtl/ulpi_link_controller_core.sv
// Top level of the ULPI link controller: stream ports, state and result registers.
//
// Each item is one sampled 60 MHz ULPI clock cycle of pins and requests; the block
// returns one result item per input item, in order. It takes one item per clock
// while the output is not stalled; each item goes from the input register to the
// result register, and the link state (access phase, pending command, last dir,
// receive and transmit flags, RX CMD status) updates once per item as it moves there.
module ulpi_link_controller_core
    import ulc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // phy_dir, phy_nxt, phy_data[7:0], req_valid, req_read, req_addr[5:0],
    // req_wdata[7:0], tx_valid, tx_data[7:0], zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // bus_out[7:0], bus_drive, stop_pin, req_done, req_rdata[7:0], rx_valid,
    // rx_sop, rx_eop, rx_byte[7:0], tx_ready, rx_status[7:0], zero fill
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic       in_valid_reg;
    logic       in_valid_next;
    in_item_t   in_item_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_item_reg;

    phase_t     phase_reg;
    logic [7:0] cmd_reg;
    logic [7:0] wdata_reg;
    logic       last_dir_reg;
    logic [7:0] status_reg;
    logic       in_receive_reg;
    logic       in_transmit_reg;

    seq_out_t   seq;
    out_item_t  result;
    logic       in_receive_next;
    logic       in_transmit_next;
    logic [7:0] status_next;

    logic       take;
    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    assign in_valid_next  = take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_item_reg;

    ulc_access u_access (
        .phase (phase_reg),
        .cmd   (cmd_reg),
        .wdata (wdata_reg),
        .item  (in_item_reg),
        .seq   (seq)
    );

    ulc_frame u_frame (
        .item             (in_item_reg),
        .seq              (seq),
        .last_dir         (last_dir_reg),
        .in_receive       (in_receive_reg),
        .in_transmit      (in_transmit_reg),
        .status           (status_reg),
        .result           (result),
        .in_receive_next  (in_receive_next),
        .in_transmit_next (in_transmit_next),
        .status_next      (status_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_IDLE;
            cmd_reg         <= 8'h00;
            last_dir_reg    <= 1'b0;
            status_reg      <= 8'h00;
            in_receive_reg  <= 1'b0;
            in_transmit_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg       <= seq.phase;
                cmd_reg         <= seq.cmd;
                last_dir_reg    <= in_item_reg.phy_dir;
                status_reg      <= status_next;
                in_receive_reg  <= in_receive_next;
                in_transmit_reg <= in_transmit_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= s_tdata;
        end
        if (advance)
        begin
            out_item_reg <= result;
            if (seq.wdata_we)
            begin
                wdata_reg <= in_item_reg.req_wdata;
            end
        end
    end

endmodule

FILE: hw/rtl/ulc_access.sv
// Register access sequencer: next phase, command and bus byte for one cycle.
module ulc_access
    import ulc_pkg::*;
(
    input  phase_t     phase,
    input  logic [7:0] cmd,
    input  logic [7:0] wdata,
    input  in_item_t   item,
    output seq_out_t   seq
);

    always_comb
    begin
        seq.bus      = 8'h00;
        seq.stp      = 1'b0;
        seq.done     = 1'b0;
        seq.rdata    = 8'h00;
        seq.phase    = phase;
        seq.cmd      = cmd;
        seq.wdata_we = 1'b0;
        unique case (phase)
            PH_IDLE:
            begin
                if (cmd[7])
                begin
                    seq.phase = PH_WAIT_DIR_OUT;
                end
                if (item.req_valid)
                begin
                    seq.cmd      = {(item.req_read ? CMD_READ_CODE : CMD_WRITE_CODE),
                                    item.req_addr};
                    seq.wdata_we = 1'b1;
                end
            end
            PH_WAIT_DIR_OUT:
            begin
                if (!item.phy_dir)
                begin
                    seq.phase = PH_SET_ADDR;
                end
            end
            PH_SET_ADDR:
            begin
                seq.bus = cmd;
                if (item.phy_nxt)
                begin
                    seq.phase = cmd[6] ? PH_WAIT_DIR_IN : PH_SET_DATA;
                end
            end
            PH_SET_DATA:
            begin
                seq.bus  = wdata;
                seq.done = 1'b1;
                seq.cmd  = 8'h00;
                if (item.phy_nxt)
                begin
                    seq.phase = PH_STOP;
                end
            end
            PH_STOP:
            begin
                seq.stp   = 1'b1;
                seq.phase = PH_IDLE;
            end
            PH_WAIT_DIR_IN:
            begin
                if (item.phy_dir)
                begin
                    seq.phase = PH_GET_DATA;
                end
            end
            PH_GET_DATA:
            begin
                seq.done  = 1'b1;
                seq.rdata = item.phy_data;
                seq.cmd   = 8'h00;
                seq.phase = PH_IDLE;
            end
            default:
            begin
                seq.phase = PH_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/ulc_frame.sv
// Receive framing, RX CMD status capture and transmit bus selection.
module ulc_frame
    import ulc_pkg::*;
(
    input  in_item_t   item,
    input  seq_out_t   seq,
    input  logic       last_dir,
    input  logic       in_receive,
    input  logic       in_transmit,
    input  logic [7:0] status,
    output out_item_t  result,
    output logic       in_receive_next,
    output logic       in_transmit_next,
    output logic [7:0] status_next
);

    logic       rx_valid;
    logic       eop;
    logic       tx_ready;
    logic [7:0] bus;
    logic       stp;

    assign rx_valid = item.phy_dir && last_dir && item.phy_nxt;
    assign tx_ready = !item.phy_dir && !last_dir && item.phy_nxt;
    assign eop = in_receive && (!item.phy_dir || (!item.phy_nxt && !item.phy_data[4]));

    // A packet end seen together with a valid byte still closes the packet.
    assign in_receive_next = eop ? 1'b0 : (rx_valid ? 1'b1 : in_receive);

    assign status_next = (item.phy_dir && last_dir && !item.phy_nxt) ? item.phy_data : status;

    always_comb
    begin
        bus              = item.tx_valid ? item.tx_data : seq.bus;
        stp              = seq.stp;
        in_transmit_next = in_transmit;
        if (!in_transmit && item.tx_valid)
        begin
            bus = {TXCMD_NIBBLE, item.tx_data[3:0]};
            if (tx_ready)
            begin
                in_transmit_next = 1'b1;
            end
        end
        else if (in_transmit && !item.tx_valid)
        begin
            stp              = 1'b1;
            in_transmit_next = 1'b0;
        end
    end

    always_comb
    begin
        result.pad       = 1'b0;
        result.rx_status = status;
        result.tx_ready  = tx_ready;
        result.rx_byte   = item.phy_data;
        result.rx_eop    = eop;
        result.rx_sop    = !in_receive && rx_valid;
        result.rx_valid  = rx_valid;
        result.req_rdata = seq.rdata;
        result.req_done  = seq.done;
        result.stop_pin  = stp;
        result.bus_drive = !item.phy_dir && !last_dir;
        result.bus_out   = bus;
    end

endmodule

FILE: tb/ulc_link_checker.sv
`timescale 1ns / 1ps
// Checker for the ULPI link controller: predicts every result item and compares it.
module ulc_link_checker
    import ulc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    mismatches,
    output int                    outstanding,
    output int                    items_checked,
    output int                    data_phases,
    output int                    rx_packets,
    output int                    stp_pulses
);

    localparam int PRINT_LIMIT = 40;

    // Shadow copy of the link state.
    phase_t     acc_phase;
    logic [7:0] cmd_byte;
    logic [7:0] wdata_byte;
    logic [7:0] rxcmd_status;
    logic       dir_q;
    logic       receiving;
    logic       transmitting;

    out_item_t  link_results_q[$];

    // Works out the pins and flags of one ULPI cycle and advances the shadow state.
    function automatic out_item_t predict_link_cycle(input in_item_t c);
        out_item_t  r;
        phase_t     nph;
        logic [7:0] ncmd;
        logic [7:0] nwdata;
        r      = '0;
        nph    = acc_phase;
        ncmd   = cmd_byte;
        nwdata = wdata_byte;
        r.bus_drive = !c.phy_dir && !dir_q;
        r.rx_status = rxcmd_status;
        r.rx_byte   = c.phy_data;

        case (acc_phase)
            PH_IDLE:
            begin
                if (cmd_byte[7])
                    nph = PH_WAIT_DIR_OUT;
                if (c.req_valid)
                begin
                    ncmd   = {(c.req_read ? CMD_READ_CODE : CMD_WRITE_CODE), c.req_addr};
                    nwdata = c.req_wdata;
                end
            end
            PH_WAIT_DIR_OUT:
            begin
                if (!c.phy_dir)
                    nph = PH_SET_ADDR;
            end
            PH_SET_ADDR:
            begin
                r.bus_out = cmd_byte;
                if (c.phy_nxt)
                    nph = cmd_byte[6] ? PH_WAIT_DIR_IN : PH_SET_DATA;
            end
            PH_SET_DATA:
            begin
                r.bus_out  = wdata_byte;
                r.req_done = 1'b1;
                ncmd       = '0;
                if (c.phy_nxt)
                    nph = PH_STOP;
            end
            PH_STOP:
            begin
                r.stop_pin = 1'b1;
                nph        = PH_IDLE;
            end
            PH_WAIT_DIR_IN:
            begin
                if (c.phy_dir)
                    nph = PH_GET_DATA;
            end
            PH_GET_DATA:
            begin
                r.req_done  = 1'b1;
                r.req_rdata = c.phy_data;
                ncmd        = '0;
                nph         = PH_IDLE;
            end
            default:
                nph = PH_IDLE;
        endcase

        // An RX CMD is a PHY-driven cycle after turnaround with nxt low.
        if (c.phy_dir && dir_q && !c.phy_nxt)
            rxcmd_status = c.phy_data;

        r.rx_valid = c.phy_dir && dir_q && c.phy_nxt;
        r.rx_sop   = !receiving && r.rx_valid;
        r.rx_eop   = receiving && (!c.phy_dir || (!c.phy_nxt && !c.phy_data[4]));
        if (r.rx_valid)
            receiving = 1'b1;
        if (r.rx_eop)
            receiving = 1'b0;

        r.tx_ready = !c.phy_dir && !dir_q && c.phy_nxt;
        if (c.tx_valid)
            r.bus_out = c.tx_data;
        if (!transmitting && c.tx_valid)
        begin
            // Until the PHY takes the first byte, it goes out as a TX CMD.
            r.bus_out = {TXCMD_NIBBLE, r.bus_out[3:0]};
            if (r.tx_ready)
                transmitting = 1'b1;
        end
        else if (transmitting && !c.tx_valid)
        begin
            r.stop_pin   = 1'b1;
            transmitting = 1'b0;
        end

        acc_phase  = nph;
        cmd_byte   = ncmd;
        wdata_byte = nwdata;
        dir_q      = c.phy_dir;
        return r;
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t ns: result item %0d: %s", $time, items_checked, what);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s is %02h, predicted %02h", name, got, want));
    endtask

    task automatic check_bit(input string name, input logic got, input logic want);
        if (got !== want)
            note_mismatch($sformatf("%s is %0b, predicted %0b", name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        out_item_t got;
        out_item_t want;
        out_item_t pred;
        if (!rst_n)
        begin
            acc_phase    = PH_IDLE;
            cmd_byte     = '0;
            wdata_byte   = '0;
            dir_q        = 1'b0;
            rxcmd_status = '0;
            receiving    = 1'b0;
            transmitting = 1'b0;
            link_results_q.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pred           = predict_link_cycle(in_item_t'(s_tdata));
                link_results_q = {link_results_q, pred};
            end
            if (m_tvalid && m_tready)
            begin
                got = out_item_t'(m_tdata);
                if (link_results_q.size() == 0)
                    note_mismatch("result item arrived with nothing predicted");
                else
                begin
                    want = link_results_q.pop_front();
                    check_field("bus_out",   got.bus_out,   want.bus_out);
                    check_bit("bus_drive",   got.bus_drive, want.bus_drive);
                    check_bit("stop_pin",    got.stop_pin,  want.stop_pin);
                    check_bit("req_done",    got.req_done,  want.req_done);
                    check_field("req_rdata", got.req_rdata, want.req_rdata);
                    check_bit("rx_valid",    got.rx_valid,  want.rx_valid);
                    check_bit("rx_sop",      got.rx_sop,    want.rx_sop);
                    check_bit("rx_eop",      got.rx_eop,    want.rx_eop);
                    check_field("rx_byte",   got.rx_byte,   want.rx_byte);
                    check_bit("tx_ready",    got.tx_ready,  want.tx_ready);
                    check_field("rx_status", got.rx_status, want.rx_status);
                    items_checked++;
                    data_phases += int'(want.req_done);
                    rx_packets  += int'(want.rx_sop);
                    stp_pulses  += int'(want.stop_pin);
                end
            end
        end
        outstanding = link_results_q.size();
    end

endmodule

FILE: tb/tb_ulpi_link_controller_core.sv
`timescale 1ns / 1ps
// Testbench top for the ULPI link controller: stimulus, handshake idling and verdict.
module tb_ulpi_link_controller_core;
    import ulc_pkg::*;

    localparam int RANDOM_ITEMS   = 1500;
    localparam int IDLE_PCT       = 23;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tready = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;

    bit gaps_on      = 1'b1;
    int items_sent   = 0;
    int stall_cycles = 0;

    int mismatches;
    int outstanding;
    int items_checked;
    int data_phases;
    int rx_packets;
    int stp_pulses;

    always #5 clk = ~clk;

    ulpi_link_controller_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ulc_link_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .items_checked (items_checked),
        .data_phases   (data_phases),
        .rx_packets    (rx_packets),
        .stp_pulses    (stp_pulses)
    );

    always @(posedge clk)
        m_tready <= rst_n && (!gaps_on || $urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic in_item_t any_item();
        logic [63:0] raw;
        in_item_t    r;
        raw   = {$urandom, $urandom};
        r     = raw[IN_DATA_W-1:0];
        r.pad = '0;
        return r;
    endfunction

    // A cycle with given pin values and no request or transmit byte.
    function automatic in_item_t pin_item(input bit dir, input bit nxt,
                                          input logic [7:0] data);
        in_item_t r;
        r           = any_item();
        r.req_valid = 1'b0;
        r.tx_valid  = 1'b0;
        r.phy_dir   = dir;
        r.phy_nxt   = nxt;
        r.phy_data  = data;
        return r;
    endfunction

    task automatic drive_item(input in_item_t it);
        while (gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic run_register_access(input bit rd);
        in_item_t it;
        int       len;
        int       turn;
        it           = pin_item(1'b0, 1'($urandom_range(1)), 8'($urandom));
        it.req_valid = 1'b1;
        it.req_read  = rd;
        drive_item(it);
        len  = $urandom_range(4, 10);
        turn = $urandom_range(2, 5);
        for (int i = 0; i < len; i++)
        begin
            it = pin_item(1'b0, $urandom_range(99) < 65, 8'($urandom));
            // For a read the PHY drives dir high from a randomly chosen item on.
            if (rd)
                it.phy_dir = (i >= turn);
            else if ($urandom_range(99) < 10)
                it.phy_dir = 1'b1;
            if ($urandom_range(99) < 8)
                it.req_valid = 1'b1;
            if ($urandom_range(99) < 8)
                it.tx_valid = 1'b1;
            drive_item(it);
        end
        drive_item(pin_item(1'b0, 1'b0, 8'($urandom)));
    endtask

    task automatic run_receive();
        in_item_t   it;
        int         len;
        logic [7:0] d;
        drive_item(pin_item(1'b1, 1'($urandom_range(1)), 8'($urandom)));
        len = $urandom_range(2, 12);
        for (int i = 0; i < len; i++)
        begin
            d = 8'($urandom);
            if ($urandom_range(99) < 30)
                it = pin_item(1'b1, 1'b0, d | 8'h10);
            else
                it = pin_item(1'b1, 1'b1, d);
            drive_item(it);
        end
        if ($urandom_range(1))
        begin
            d = 8'($urandom);
            drive_item(pin_item(1'b1, 1'b0, d & 8'hEF));
        end
        drive_item(pin_item(1'b0, 1'($urandom_range(1)), 8'($urandom)));
    endtask

    task automatic run_transmit();
        in_item_t it;
        int       len;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
        begin
            it          = pin_item($urandom_range(99) < 5, $urandom_range(99) < 60,
                                   8'($urandom));
            it.tx_valid = 1'b1;
            if ($urandom_range(99) < 5)
                it.req_valid = 1'b1;
            drive_item(it);
        end
        drive_item(pin_item(1'b0, 1'($urandom_range(1)), 8'($urandom)));
    endtask

    initial
    begin : stimulus
        in_item_t it;
        int       pick;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        drive_item('0);

        // Register write to the top address with all-ones data.
        it           = pin_item(1'b0, 1'b0, 8'h00);
        it.req_valid = 1'b1;
        it.req_read  = 1'b0;
        it.req_addr  = 6'h3F;
        it.req_wdata = 8'hFF;
        drive_item(it);
        drive_item(pin_item(1'b0, 1'b0, 8'h00));
        drive_item(pin_item(1'b0, 1'b0, 8'h00));
        // A request while the access is running must be ignored.
        it           = pin_item(1'b0, 1'b1, 8'h00);
        it.req_valid = 1'b1;
        drive_item(it);
        drive_item(pin_item(1'b0, 1'b1, 8'h00));
        drive_item(pin_item(1'b0, 1'b0, 8'h00));

        // Register read of address zero.
        it           = pin_item(1'b0, 1'b0, 8'h00);
        it.req_valid = 1'b1;
        it.req_read  = 1'b1;
        it.req_addr  = 6'h00;
        drive_item(it);
        drive_item(pin_item(1'b0, 1'b0, 8'h00));
        drive_item(pin_item(1'b0, 1'b0, 8'h00));
        drive_item(pin_item(1'b0, 1'b1, 8'h00));
        drive_item(pin_item(1'b1, 1'b0, 8'h5A));
        drive_item(pin_item(1'b1, 1'b0, 8'hA5));

        // Receive packet ended by RxActive going low.
        drive_item(pin_item(1'b1, 1'b1, 8'h00));
        drive_item(pin_item(1'b1, 1'b1, 8'hFF));
        drive_item(pin_item(1'b1, 1'b0, 8'h1F));
        drive_item(pin_item(1'b1, 1'b0, 8'h0E));

        // Transmit: TX CMD byte, then data, then stp.
        it          = pin_item(1'b0, 1'b0, 8'h00);
        it.tx_valid = 1'b1;
        it.tx_data  = 8'hFF;
        drive_item(it);
        it          = pin_item(1'b0, 1'b1, 8'h00);
        it.tx_valid = 1'b1;
        it.tx_data  = 8'h00;
        drive_item(it);
        it          = pin_item(1'b0, 1'b1, 8'h00);
        it.tx_valid = 1'b1;
        it.tx_data  = 8'h81;
        drive_item(it);
        drive_item(pin_item(1'b0, 1'b0, 8'h00));

        it     = '1;
        it.pad = '0;
        drive_item(it);

        while (items_sent < RANDOM_ITEMS + 25)
        begin
            gaps_on = !(items_sent >= 600 && items_sent < 900);
            pick    = $urandom_range(99);
            if (pick < 20)
                run_register_access(1'b0);
            else if (pick < 38)
                run_register_access(1'b1);
            else if (pick < 62)
                run_receive();
            else if (pick < 86)
                run_transmit();
            else
                repeat ($urandom_range(1, 4)) drive_item(any_item());
        end
        gaps_on = 1'b1;
        s_tvalid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d cycles checked: %0d register data cycles, %0d receive packets,",
                 items_checked, data_phases, rx_packets);
        $display("%0d stp pulses, %0d field mismatches", stp_pulses, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
